### rtl/core/assert_macros.svh
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the clock after the antecedent.
`define MRP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// The consequent must hold in the same clock as the antecedent.
`define MRP_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

`endif

### rtl/core/mrp_pkg.sv
// Package with the shared types and constants of the primality tester.
package mrp_pkg;

  // Fixed witness bases: the first ten primes, 2 to 29.
  localparam int BASE_COUNT = 10;
  localparam int BASE_IDX_W = $clog2(BASE_COUNT);

  typedef logic [4:0] base_t;

  localparam base_t TEST_BASES [BASE_COUNT] = '{
    5'd2, 5'd3, 5'd5, 5'd7, 5'd11, 5'd13, 5'd17, 5'd19, 5'd23, 5'd29
  };

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_STRIP,
    S_BASE,
    S_REDUCE,
    S_MUL_GO,
    S_MUL_WAIT,
    S_NEXT,
    S_FINISH
  } state_t;

  // Which product the shared multiplier is forming.
  typedef enum logic [1:0] {
    OP_SQ,
    OP_MUL,
    OP_CHAIN
  } op_t;

endpackage

### rtl/core/mrp_modmul.sv
// Bit-serial modular multiplier: one multiplier bit per clock, MSB first.
module mrp_modmul import mrp_pkg::*; #(
  parameter int NUMBER_WIDTH = 63
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [NUMBER_WIDTH-1:0] x,
  input  logic [NUMBER_WIDTH-1:0] y,
  input  logic [NUMBER_WIDTH-1:0] m,
  output logic                    done,
  output logic [NUMBER_WIDTH-1:0] product
);

  localparam int W  = NUMBER_WIDTH;
  localparam int IW = $clog2(W);
  localparam logic [IW-1:0] TOP_BIT = IW'(W - 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [IW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]  acc_r, acc_nxt;
  logic [W-1:0]  x_r, y_r, m_r;
  logic [W:0]    dbl, dred, sum, sred;

  // One Horner step: acc = (2*acc + bit*x) mod m, both reductions by one subtract.
  always_comb begin
    dbl  = {acc_r, 1'b0};
    dred = (dbl >= {1'b0, m_r}) ? dbl - {1'b0, m_r} : dbl;
    sum  = dred + (y_r[cnt_r] ? {1'b0, x_r} : '0);
    sred = (sum >= {1'b0, m_r}) ? sum - {1'b0, m_r} : sum;
  end

  // Step control.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = TOP_BIT;
      acc_nxt  = '0;
    end else if (busy_r) begin
      acc_nxt = sred[W-1:0];
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // Operand and accumulator registers.
  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    acc_r <= acc_nxt;
    if (start) begin
      x_r <= x;
      y_r <= y;
      m_r <= m;
    end
  end

  assign done    = done_r;
  assign product = acc_r;

endmodule

### rtl/core/miller_rabin_primality_test_top.sv
// Deterministic Miller-Rabin tester: one candidate word in, one is_prime word out.
// The block takes one word at a time and holds in_stall high until it is done.
// All products go through one bit-serial modular multiplier. With n - 1 = d * 2^s,
// a base costs NUMBER_WIDTH + popcount(d) + s products (squarings from the top
// exponent bit down, one multiply per set bit, then s chain squarings), and
// popcount(d) + s stays at or below NUMBER_WIDTH. A composite usually stops
// after its first base, and a number below 2 goes straight to the finish state.
module miller_rabin_primality_test_top import mrp_pkg::*; #(
  parameter int NUMBER_WIDTH = 63
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [NUMBER_WIDTH-1:0] in_number,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_is_prime
);

  localparam int W  = NUMBER_WIDTH;
  localparam int IW = $clog2(W);
  localparam logic [IW-1:0] TOP_BIT = IW'(W - 1);
  localparam logic [BASE_IDX_W-1:0] LAST_BASE = BASE_IDX_W'(BASE_COUNT - 1);
  localparam logic [W-1:0] ONE = W'(1);

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;

  logic [W-1:0]          n_r, n_nxt;
  logic [W-1:0]          nm1_r, nm1_nxt;
  logic [W-1:0]          d_r, d_nxt;
  logic [W-1:0]          a_r, a_nxt;
  logic [W-1:0]          r_r, r_nxt;
  logic [IW-1:0]         s_r, s_nxt;
  logic [IW-1:0]         i_r, i_nxt;
  logic [IW-1:0]         j_r, j_nxt;
  logic [BASE_IDX_W-1:0] k_r, k_nxt;
  logic                  prime_r, prime_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_prime_r, out_prime_nxt;

  logic         in_fire;
  logic         out_free;
  logic         mul_start;
  logic         mul_done;
  logic [W-1:0] mul_x, mul_y, mul_p;

  // Shared modular multiplier.
  mrp_modmul #(
    .NUMBER_WIDTH(NUMBER_WIDTH)
  ) u_modmul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .x       (mul_x),
    .y       (mul_y),
    .m       (n_r),
    .done    (mul_done),
    .product (mul_p)
  );

  assign in_fire  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // Operand selection for the multiplier.
  always_comb begin
    case (op_r)
      OP_MUL: begin
        mul_x = a_r;
        mul_y = r_r;
      end
      default: begin
        mul_x = r_r;
        mul_y = r_r;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_number < W'(2)) ? S_FINISH : S_STRIP;
        end
      end
      S_STRIP: begin
        if (d_r[0]) state_nxt = S_BASE;
      end
      S_BASE: state_nxt = S_REDUCE;
      S_REDUCE: begin
        if (a_r < n_r) state_nxt = (a_r == '0) ? S_NEXT : S_MUL_GO;
      end
      S_MUL_GO: state_nxt = S_MUL_WAIT;
      S_MUL_WAIT: begin
        if (mul_done) begin
          case (op_r)
            OP_SQ: begin
              if (d_r[i_r] || i_r != '0 || s_r != '0) state_nxt = S_MUL_GO;
              else state_nxt = (mul_p == ONE) ? S_NEXT : S_FINISH;
            end
            OP_MUL: begin
              if (i_r != '0 || s_r != '0) state_nxt = S_MUL_GO;
              else state_nxt = (mul_p == ONE) ? S_NEXT : S_FINISH;
            end
            default: begin
              if (mul_p == ONE && r_r != ONE && r_r != nm1_r) state_nxt = S_FINISH;
              else if (j_r + 1'b1 == s_r) state_nxt = (mul_p == ONE) ? S_NEXT : S_FINISH;
              else state_nxt = S_MUL_GO;
            end
          endcase
        end
      end
      S_NEXT: state_nxt = (k_r == LAST_BASE) ? S_FINISH : S_BASE;
      S_FINISH: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Handshake and multiplier control outputs.
  always_comb begin
    in_stall  = 1'b1;
    mul_start = 1'b0;
    case (state_r)
      S_IDLE:   in_stall  = 1'b0;
      S_MUL_GO: mul_start = 1'b1;
      default: begin
        in_stall  = 1'b1;
        mul_start = 1'b0;
      end
    endcase
  end

  // Datapath next values.
  always_comb begin
    n_nxt         = n_r;
    nm1_nxt       = nm1_r;
    d_nxt         = d_r;
    a_nxt         = a_r;
    r_nxt         = r_r;
    s_nxt         = s_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    op_nxt        = op_r;
    prime_nxt     = prime_r;
    out_prime_nxt = out_prime_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          n_nxt     = in_number;
          nm1_nxt   = in_number - ONE;
          d_nxt     = in_number - ONE;
          s_nxt     = '0;
          k_nxt     = '0;
          prime_nxt = 1'b0;
        end
      end
      S_STRIP: begin
        if (!d_r[0]) begin
          d_nxt = d_r >> 1;
          s_nxt = s_r + 1'b1;
        end
      end
      S_BASE: a_nxt = W'(TEST_BASES[k_r]);
      S_REDUCE: begin
        if (a_r >= n_r) begin
          a_nxt = a_r - n_r;
        end else begin
          r_nxt  = ONE;
          i_nxt  = TOP_BIT;
          op_nxt = OP_SQ;
        end
      end
      S_MUL_WAIT: begin
        if (mul_done) begin
          r_nxt = mul_p;
          case (op_r)
            OP_SQ: begin
              if (d_r[i_r]) begin
                op_nxt = OP_MUL;
              end else if (i_r != '0) begin
                i_nxt = i_r - 1'b1;
              end else begin
                j_nxt  = '0;
                op_nxt = OP_CHAIN;
              end
            end
            OP_MUL: begin
              if (i_r != '0) begin
                i_nxt  = i_r - 1'b1;
                op_nxt = OP_SQ;
              end else begin
                j_nxt  = '0;
                op_nxt = OP_CHAIN;
              end
            end
            default: j_nxt = j_r + 1'b1;
          endcase
        end
      end
      S_NEXT: begin
        if (k_r == LAST_BASE) prime_nxt = 1'b1;
        else k_nxt = k_r + 1'b1;
      end
      S_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_prime_nxt = prime_r;
        end
      end
      default: begin
        prime_nxt = prime_r;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    n_r         <= n_nxt;
    nm1_r       <= nm1_nxt;
    d_r         <= d_nxt;
    a_r         <= a_nxt;
    r_r         <= r_nxt;
    s_r         <= s_nxt;
    i_r         <= i_nxt;
    j_r         <= j_nxt;
    k_r         <= k_nxt;
    op_r        <= op_nxt;
    prime_r     <= prime_nxt;
    out_prime_r <= out_prime_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_is_prime = out_prime_r;

endmodule

### rtl/core/mrp_checker.sv
// Port-level checker for the primality tester, bound to the top level.
`include "assert_macros.svh"

module mrp_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic out_is_prime
);

  // An accepted word keeps the input closed while the test runs.
  `MRP_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

  // An open input with nothing offered stays open.
  `MRP_ASSERT_NEXT(a_idle_holds, !in_stall && !in_valid, !in_stall)

  // A stalled result word stays offered.
  `MRP_ASSERT_NEXT(a_out_holds, out_valid && out_stall, out_valid)

  // A stalled result word keeps its value.
  `MRP_ASSERT_SAME(a_out_stable, $past(out_valid && out_stall), $stable(out_is_prime))

endmodule

bind miller_rabin_primality_test_top mrp_checker u_mrp_checker (.*);

### tb/sv/tb.sv
// Testbench for the Miller-Rabin primality tester: driven candidates, checked verdicts.
module tb;
  import mrp_pkg::*;

  localparam int NW = 63;
  localparam int CYCLE_LIMIT = 100000000;
  localparam int SETTLE_CYCLES = 100;
  localparam int HOLD_CYCLES = 100000;
  localparam int QUIET_TAIL = 20;

  typedef logic [NW-1:0] num_t;

  typedef struct {
    num_t number;
    logic prime;
  } candidate_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  num_t in_number;
  logic out_valid;
  logic out_stall;
  logic out_is_prime;

  candidate_t pending_words[$];
  candidate_t verdicts_due[$];
  candidate_t next_word;
  int errors = 0;
  int cycles = 0;
  int accepted = 0;
  int send_gap = 0;
  int recv_gap = 0;
  int hold_left = 0;
  bit hold_done = 0;

  miller_rabin_primality_test_top #(.NUMBER_WIDTH(NW)) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_number(in_number),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_is_prime(out_is_prime)
  );

  // Clock with a period of 8.
  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Exact product modulo m through a 128-bit intermediate.
  function automatic num_t mul_mod(num_t x, num_t y, num_t m);
    logic [127:0] prod;
    prod = {65'b0, x} * {65'b0, y};
    return num_t'(prod % {65'b0, m});
  endfunction

  function automatic num_t pow_mod(num_t a, num_t e, num_t m);
    num_t r;
    r = num_t'(1) % m;
    a = a % m;
    while (e != 0) begin
      if (e[0]) r = mul_mod(r, a, m);
      a = mul_mod(a, a, m);
      e = e >> 1;
    end
    return r;
  endfunction

  // True when witness a fails to show that n is composite.
  function automatic bit witness_passes(num_t n, num_t a);
    num_t d;
    num_t cur;
    num_t nxt;
    int s;
    d = n - 1;
    s = 0;
    if (a % n == 0) return 1'b1;
    while (d[0] == 1'b0 && d != 0) begin
      d = d >> 1;
      s++;
    end
    cur = pow_mod(a, d, n);
    for (int i = 0; i < s; i++) begin
      nxt = mul_mod(cur, cur, n);
      if (nxt == 1 && cur != 1 && cur != n - 1) return 1'b0;
      cur = nxt;
    end
    return cur == 1;
  endfunction

  function automatic logic primality(num_t n);
    if (n < 2) return 1'b0;
    for (int k = 0; k < BASE_COUNT; k++) begin
      if (!witness_passes(n, num_t'(TEST_BASES[k]))) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic num_t rand_word();
    return num_t'({$urandom, $urandom});
  endfunction

  // Next prime at or above a random odd start within the given bit count.
  function automatic num_t prime_near(int bits);
    num_t c;
    c = rand_word() >> (NW - bits);
    c[0] = 1'b1;
    if (c < 3) c = 3;
    while (!primality(c)) begin
      c = c + 2;
    end
    return c;
  endfunction

  task automatic queue_word(num_t n);
    candidate_t c;
    c.number = n;
    c.prime = primality(n);
    pending_words.push_back(c);
  endtask

  task automatic report_mismatch(string what, num_t n, logic got, logic want);
    $display("MISMATCH %s: number %0d is_prime %0b, expected %0b", what, n, got, want);
    errors++;
  endtask

  // Sender: offers the queued words, with random bursts of idle cycles.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_number <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        verdicts_due.push_back(candidate_t'{in_number, primality(in_number)});
        accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          next_word = pending_words.pop_front();
          in_valid <= 1'b1;
          in_number <= next_word.number;
          if (pending_words.size() > QUIET_TAIL && $urandom_range(0, 3) == 0)
            send_gap = $urandom_range(1, 16);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall: one long hold early on, random bursts later, none at the tail.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (!hold_done && accepted >= 6) begin
      hold_done = 1;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (recv_gap > 0) begin
      recv_gap--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if (pending_words.size() > QUIET_TAIL && $urandom_range(0, 3) == 0)
        recv_gap = $urandom_range(1, 16);
    end
  end

  // Monitor: each verdict word against the oldest one due.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (verdicts_due.size() == 0) begin
        report_mismatch("unexpected word", '0, out_is_prime, 1'bx);
      end else begin
        candidate_t c;
        c = verdicts_due.pop_front();
        if (out_is_prime !== c.prime) report_mismatch("is_prime", c.number, out_is_prime, c.prime);
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    num_t p;
    num_t q;
    int pick;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_number = '0;
    out_stall = 1'b0;

    // Directed words: small numbers, the bases themselves, evens, pseudoprimes, extremes.
    queue_word(0);
    queue_word(1);
    queue_word(2);
    queue_word(3);
    queue_word(4);
    for (int k = 2; k < BASE_COUNT; k++) queue_word(num_t'(TEST_BASES[k]));
    queue_word(31);
    queue_word(561);
    queue_word(2047);
    queue_word(num_t'(64'd3215031751));
    queue_word({NW{1'b1}});
    queue_word({NW{1'b1}} - 24);
    queue_word({1'b1, {(NW-1){1'b0}}});
    queue_word({NW{1'b1}} - 1);
    queue_word(num_t'(64'h2AAA_AAAA_AAAA_AAAB));
    queue_word(num_t'(64'h5555_5555_5555_5555));

    // Random words: mostly composites, some products of primes, a few primes.
    for (int i = 0; i < 280; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        queue_word(rand_word());
      end else if (pick < 60) begin
        queue_word(rand_word() >> $urandom_range(1, NW - 1));
      end else if (pick < 70) begin
        p = rand_word();
        p[0] = 1'b0;
        queue_word(p);
      end else if (pick < 90) begin
        p = prime_near($urandom_range(4, 31));
        q = prime_near($urandom_range(4, 31));
        queue_word(p * q);
      end else if (pick < 95) begin
        queue_word(num_t'($urandom_range(0, 40)));
      end else begin
        queue_word(prime_near($urandom_range(8, NW)));
      end
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_words.size() > 0 || in_valid || verdicts_due.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/mrp_pkg.sv
rtl/core/mrp_modmul.sv
rtl/core/miller_rabin_primality_test_top.sv
rtl/core/mrp_checker.sv
tb/sv/tb.sv
